>>> rtl/chained_hash_set_engine_core_macros.svh
// Assertion macros shared by the checker of the chained hash set engine.
// Expects signals named clk and rst in the scope of use.
`ifndef CHAINED_HASH_SET_ENGINE_CORE_MACROS_SVH
`define CHAINED_HASH_SET_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define CHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/chs_pkg.sv
// Package of the chained hash set engine: fixed word widths, request codes,
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps

package chs_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_IN_W = 32;
  localparam int COUNT_W = 11;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

  // Controller to datapath: at most one phase strobe per cycle; reject rides
  // along with the head or step strobe that ends the search.
  typedef struct packed {
    logic start;      // latch request, read bucket head
    logic head;       // take head, read first node
    logic step;       // compare node, advance along chain
    logic reject;     // flag insert refused for empty pool
    logic alloc_wr;   // link new node at chain head
    logic unlink;     // bypass matching node
    logic free_node;  // push matching node on free list
    logic publish;    // load response register
  } chs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic              head_nil;
    logic              key_hit;
    logic              link_nil;
    logic              pool_empty;
    logic              fresh_next;
    logic [KIND_W-1:0] kind;
  } chs_stat_t;

endpackage

>>> rtl/chs_ifs.sv
// Valid/ready channel interfaces of the chained hash set engine.
// Depends on chs_pkg for the word widths.
`timescale 1ns / 1ps

interface chs_req_if import chs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_IN_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

interface chs_rsp_if import chs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               was_present;
  logic               rejected;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output was_present, output rejected, output count,
                  input ready);
  modport sink (input valid, input was_present, input rejected, input count,
                output ready);
endinterface

>>> rtl/chained_hash_set_engine_core.sv
// Chained hash set engine: a set of keys in a chained hash table.
//
// req channel: kind (insert, remove, query; the spare code acts as query)
// and key. rsp channel: one word per request with was_present, rejected
// (insert of a new key with the node pool full) and the resulting count.
// Both channels are valid/ready; a word moves when valid and ready are high.
//
// Sequence: one request at a time. After accept the engine reads the bucket
// head, then compares the chain nodes one per cycle through the node memories'
// registered read. An insert of a new key then links a node, first reading the
// freed node it reuses; a remove unlinks the match and frees it. req.ready
// rises again together with response valid.
//
// Reset (rst, synchronous): all buckets empty, count zero, whole pool free.
// Bucket heads carry a valid bit each; the pool needs no clearing pass since
// untouched nodes are tracked by a fill mark. Ready to accept right after.
//
// Stall: the response register holds its word while rsp.ready is low, and a
// new request may still be accepted; it completes its search and waits in
// its last step until the register frees up.
`timescale 1ns / 1ps

module chained_hash_set_engine_core import chs_pkg::*; #(
  parameter int BUCKETS   = 256,
  parameter int NODES     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  chs_req_if.sink   req,
  chs_rsp_if.source rsp
);

  chs_cmd_t  cmd;
  chs_stat_t stat;

  // Sequencer: owns the handshakes and the response valid flag.
  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Memories, free list and response payload.
  chs_dp #(
    .BUCKETS   (BUCKETS),
    .NODES     (NODES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_kind         (req.kind),
    .in_key          (req.key),
    .stat            (stat),
    .out_was_present (rsp.was_present),
    .out_rejected    (rsp.rejected),
    .out_count       (rsp.count)
  );

endmodule

>>> rtl/chs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/chs_ctrl.sv
// Request sequencer of the chained hash set engine: walks the chain, then
// issues the list updates and the response load. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_ctrl import chs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  chs_stat_t stat,
  output chs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_UNLINK,
    S_FREE,
    S_DONE
  } state_t;

  state_t state, state_next;

  // Pick the update phase once the search has ended.
  function automatic state_t after_search(input logic found, input chs_stat_t s);
    state_t nxt;
    nxt = S_DONE;
    if (s.kind == KIND_INSERT && !found && !s.pool_empty) begin
      nxt = s.fresh_next ? S_ALLOC_WR : S_ALLOC_RD;
    end else if (s.kind == KIND_REMOVE && found) begin
      nxt = S_UNLINK;
    end
    return nxt;
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head = 1'b1;
        if (stat.head_nil) begin
          cmd.reject = (stat.kind == KIND_INSERT) && stat.pool_empty;
          state_next = after_search(1'b0, stat);
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.key_hit) begin
          state_next = after_search(1'b1, stat);
        end else if (stat.link_nil) begin
          cmd.reject = (stat.kind == KIND_INSERT) && stat.pool_empty;
          state_next = after_search(1'b0, stat);
        end
      end
      S_ALLOC_RD: begin
        state_next = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd.free_node = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/chs_dp.sv
// Datapath of the chained hash set engine: bucket head and node memories,
// free list, fill count, key count and response register. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_dp import chs_pkg::*; #(
  parameter int BUCKETS   = 256,
  parameter int NODES     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  chs_cmd_t            cmd,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [KEY_IN_W-1:0] in_key,
  output chs_stat_t           stat,
  output logic                out_was_present,
  output logic                out_rejected,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int NW  = $clog2(NODES + 1);   // node index with room for null
  localparam int NAW = $clog2(NODES);
  localparam int BW  = $clog2(BUCKETS);
  localparam int KB  = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam logic [NW-1:0] NIL = NW'(NODES);

  logic [KIND_W-1:0] req_kind;
  logic [KB-1:0]     req_key;
  logic [BW-1:0]     req_bucket;
  logic [NW-1:0]     head, cur, prev, hit_link;
  logic              found, rej;
  logic [NW-1:0]     free_head, fresh, count;
  logic [BUCKETS-1:0] bvalid;

  logic [BW-1:0]  bmod [256];
  logic [BW-1:0]  in_bucket;
  logic [NW-1:0]  head_now;

  logic           b_we;
  logic [BW-1:0]  b_waddr, b_raddr;
  logic [NW-1:0]  b_wdata, b_rdata;
  logic           k_we, l_we;
  logic [NAW-1:0] n_waddr, n_raddr;
  logic [NW-1:0]  l_wdata, l_rdata;
  logic [KB-1:0]  k_rdata;

  // Bucket of a key: its low byte folded onto the bucket count.
  for (genvar g = 0; g < 256; g++) begin : g_bmod
    assign bmod[g] = BW'(g % BUCKETS);
  end

  assign in_bucket = bmod[in_key[7:0]];
  assign head_now  = bvalid[req_bucket] ? b_rdata : NIL;
  assign b_raddr   = cmd.start ? in_bucket : req_bucket;
  assign n_raddr   = cmd.head ? head_now[NAW-1:0] :
                     cmd.step ? l_rdata[NAW-1:0] : free_head[NAW-1:0];

  always_comb begin
    b_we    = 1'b0;
    b_waddr = req_bucket;
    b_wdata = free_head;
    k_we    = 1'b0;
    l_we    = 1'b0;
    n_waddr = free_head[NAW-1:0];
    l_wdata = head;
    if (cmd.alloc_wr) begin
      b_we = 1'b1;
      k_we = 1'b1;
      l_we = 1'b1;
    end
    if (cmd.unlink) begin
      if (prev != NIL) begin
        l_we    = 1'b1;
        n_waddr = prev[NAW-1:0];
        l_wdata = hit_link;
      end else begin
        b_we    = 1'b1;
        b_wdata = hit_link;
      end
    end
    if (cmd.free_node) begin
      l_we    = 1'b1;
      n_waddr = cur[NAW-1:0];
      l_wdata = free_head;
    end
  end

  chs_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  chs_ram #(.WIDTH(KB), .DEPTH(NODES)) u_keys (
    .clk(clk), .we(k_we), .waddr(n_waddr), .wdata(req_key),
    .raddr(n_raddr), .rdata(k_rdata)
  );

  chs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_links (
    .clk(clk), .we(l_we), .waddr(n_waddr), .wdata(l_wdata),
    .raddr(n_raddr), .rdata(l_rdata)
  );

  assign stat.head_nil   = (head_now == NIL);
  assign stat.key_hit    = (k_rdata == req_key);
  assign stat.link_nil   = (l_rdata == NIL);
  assign stat.pool_empty = (free_head == NIL);
  assign stat.fresh_next = (free_head == fresh);
  assign stat.kind       = req_kind;

  // Pool state. Nodes at or above fresh were never handed out and link to
  // the next index implicitly.
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid    <= '0;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
    end else begin
      if (cmd.alloc_wr) begin
        bvalid[req_bucket] <= 1'b1;
        free_head <= (free_head == fresh) ? free_head + NW'(1) : l_rdata;
        if (free_head == fresh) begin
          fresh <= fresh + NW'(1);
        end
        count <= count + NW'(1);
      end
      if (cmd.free_node) begin
        free_head <= cur;
        count     <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_kind   <= in_kind;
      req_key    <= in_key[KB-1:0];
      req_bucket <= in_bucket;
      found      <= 1'b0;
      rej        <= 1'b0;
    end
    if (cmd.head) begin
      head <= head_now;
      cur  <= head_now;
      prev <= NIL;
    end
    if (cmd.step) begin
      if (k_rdata == req_key) begin
        found    <= 1'b1;
        hit_link <= l_rdata;
      end else begin
        prev <= cur;
        cur  <= l_rdata;
      end
    end
    if (cmd.reject) begin
      rej <= 1'b1;
    end
    if (cmd.publish) begin
      out_was_present <= found;
      out_rejected    <= rej;
      out_count       <= COUNT_W'(count);
    end
  end

endmodule

>>> rtl/chs_checker.sv
// Port-level checker of the chained hash set engine, bound to the top level.
// Depends on chs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "chained_hash_set_engine_core_macros.svh"

module chs_checker import chs_pkg::*; #(
  parameter int NODES = 1024
) (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               was_present,
  input logic               rejected,
  input logic [COUNT_W-1:0] count
);

  // A refused insert was for an absent key.
  `CHS_ASSERT_NOW(a_rej_absent, rsp_valid && rejected, !was_present, "rejected with key present")

  // Refusal only happens with every node in use.
  `CHS_ASSERT_NOW(a_rej_full, rsp_valid && rejected, count == COUNT_W'(NODES), "rejected below full")

  // No response right out of reset.
  `CHS_ASSERT_NOW(a_rst_quiet, $past(rst), !rsp_valid, "response after reset")

  // A stalled response word holds.
  `CHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(count) && $stable(was_present) && $stable(rejected), "response changed under stall")

endmodule

bind chained_hash_set_engine_core chs_checker #(.NODES(NODES)) u_chs_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .was_present (rsp.was_present),
  .rejected    (rsp.rejected),
  .count       (rsp.count)
);
